// ===== rtl/okvt_pkg.sv =====
// Package for the ordered key/value table: sizes, command and status codes,
// and the queue entry type shared by the front end, the queue and the back end.
// No dependencies.
package okvt_pkg;

   localparam int CAPACITY   = 6;
   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 63;
   localparam int CMD_BITS   = 3;
   localparam int STAT_BITS  = 2;
   localparam int POS_BITS   = 3;
   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int QDEPTH     = 2;
   localparam int QPTR_BITS  = 1;
   localparam int QCNT_BITS  = 2;

   // Command codes as they arrive on req_command.
   localparam logic [CMD_BITS-1:0] CMD_INS_FRONT = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_APPEND    = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_ERASE     = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_SET_VALUE = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_LOOKUP    = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_RENAME    = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR     = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_UNUSED    = 3'd7;

   // Internal operation after classification.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_INS_FRONT,
      OP_APPEND,
      OP_ERASE,
      OP_SET_VALUE,
      OP_LOOKUP,
      OP_RENAME,
      OP_CLEAR
   } op_type;

   localparam logic [STAT_BITS-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_BITS-1:0] ST_DUP     = 2'd1;
   localparam logic [STAT_BITS-1:0] ST_FULL    = 2'd2;
   localparam logic [STAT_BITS-1:0] ST_MISSING = 2'd3;

   typedef struct packed {
      op_type                op;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [KEY_BITS-1:0]   new_key;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== rtl/okvt_front.sv =====
// Front end of the ordered key/value table: takes commands, classifies them
// and stages them toward the command queue. Depends on okvt_pkg.
module okvt_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [okvt_pkg::CMD_BITS-1:0]   req_command,
   input  logic [okvt_pkg::KEY_BITS-1:0]   req_key,
   input  logic [okvt_pkg::VALUE_BITS-1:0] req_value,
   input  logic [okvt_pkg::KEY_BITS-1:0]   req_new_key,
   input  okvt_pkg::qstat_type             q_stat,
   output logic                           q_push,
   output okvt_pkg::entry_type            q_data
);
   import okvt_pkg::*;

   logic      stage_valid_ff, stage_valid_in;
   entry_type stage_ff;
   op_type    op_dec;
   logic      take;

   always_comb begin
      unique case (req_command)
         CMD_INS_FRONT: op_dec = OP_INS_FRONT;
         CMD_APPEND:    op_dec = OP_APPEND;
         CMD_ERASE:     op_dec = OP_ERASE;
         CMD_SET_VALUE: op_dec = OP_SET_VALUE;
         CMD_LOOKUP:    op_dec = OP_LOOKUP;
         CMD_RENAME:    op_dec = OP_RENAME;
         CMD_CLEAR:     op_dec = OP_CLEAR;
         CMD_UNUSED:    op_dec = OP_NOP;
         default:       op_dec = OP_NOP;
      endcase
   end

   // Hold the staged command while the queue is full.
   assign busy   = stage_valid_ff & q_stat.full;
   assign take   = start & ~busy;
   assign q_push = stage_valid_ff & ~q_stat.full;
   assign q_data = stage_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (q_push) begin
         stage_valid_in = 1'b0;
      end
      if (take) begin
         stage_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (take) begin
         stage_ff.op      <= op_dec;
         stage_ff.key     <= req_key;
         stage_ff.value   <= req_value;
         stage_ff.new_key <= req_new_key;
      end
   end

endmodule

// ===== rtl/okvt_queue.sv =====
// Short command queue between the front end and the back end of the
// ordered key/value table. Depends on okvt_pkg.
module okvt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  okvt_pkg::entry_type push_data,
   input  logic                pop,
   output okvt_pkg::entry_type head,
   output okvt_pkg::qstat_type stat
);
   import okvt_pkg::*;

   entry_type            slot_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign stat.full  = (fill_ff == QCNT_BITS'(QDEPTH));
   assign stat.empty = (fill_ff == '0);
   assign do_push    = push & ~stat.full;
   assign do_pop     = pop & ~stat.empty;
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/okvt_back.sv =====
// Back end of the ordered key/value table: holds the slots, runs one queued
// command per cycle and registers the result. Depends on okvt_pkg.
module okvt_back (
   input  logic                            clock,
   input  logic                            reset,
   input  okvt_pkg::qstat_type             q_stat,
   input  okvt_pkg::entry_type             q_head,
   output logic                            q_pop,
   output logic                            rsp_strobe,
   output logic [okvt_pkg::STAT_BITS-1:0]  rsp_status,
   output logic [okvt_pkg::POS_BITS-1:0]   rsp_position,
   output logic [okvt_pkg::VALUE_BITS-1:0] rsp_found_value,
   output logic [okvt_pkg::POS_BITS-1:0]   rsp_entry_count
);
   import okvt_pkg::*;

   logic [KEY_BITS-1:0]   key_slots_ff [CAPACITY];
   logic [KEY_BITS-1:0]   key_slots_in [CAPACITY];
   logic [VALUE_BITS-1:0] value_slots_ff [CAPACITY];
   logic [VALUE_BITS-1:0] value_slots_in [CAPACITY];
   logic [CNT_BITS-1:0]   count_ff, count_in;

   logic                  strobe_ff;
   logic [STAT_BITS-1:0]  status_ff, status_in;
   logic [POS_BITS-1:0]   position_ff, position_in;
   logic [VALUE_BITS-1:0] fval_ff, fval_in;
   logic [POS_BITS-1:0]   ecount_ff;

   logic [CAPACITY-1:0]   hit, nhit;
   logic [IDX_BITS-1:0]   at;
   logic                  found, nfound, full;
   logic [IDX_BITS-1:0]   tail;

   assign q_pop = ~q_stat.empty;
   assign tail  = count_ff[IDX_BITS-1:0];
   assign full  = (count_ff >= CNT_BITS'(CAPACITY));

   // Parallel compare over live slots; keys are unique so hits are one-hot.
   always_comb begin
      at = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit[i]  = (CNT_BITS'(i) < count_ff) && (key_slots_ff[i] == q_head.key);
         nhit[i] = (CNT_BITS'(i) < count_ff) && (key_slots_ff[i] == q_head.new_key);
         if (hit[i]) begin
            at = at | IDX_BITS'(i);
         end
      end
      found  = |hit;
      nfound = |nhit;
   end

   always_comb begin
      key_slots_in   = key_slots_ff;
      value_slots_in = value_slots_ff;
      count_in       = count_ff;
      status_in      = ST_OK;
      position_in    = '0;
      fval_in        = '0;
      unique case (q_head.op) inside
         OP_INS_FRONT, OP_APPEND: begin
            if (found) begin
               status_in = ST_DUP;
            end else if (full) begin
               status_in = ST_FULL;
            end else if (q_head.op == OP_INS_FRONT) begin
               for (int i = CAPACITY - 1; i > 0; i--) begin
                  key_slots_in[i]   = key_slots_ff[i-1];
                  value_slots_in[i] = value_slots_ff[i-1];
               end
               key_slots_in[0]   = q_head.key;
               value_slots_in[0] = q_head.value;
               count_in          = count_ff + 1'b1;
            end else begin
               key_slots_in[tail]   = q_head.key;
               value_slots_in[tail] = q_head.value;
               position_in          = POS_BITS'(tail);
               count_in             = count_ff + 1'b1;
            end
         end
         OP_ERASE: begin
            if (!found) begin
               status_in = ST_MISSING;
            end else begin
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (IDX_BITS'(i) >= at) begin
                     key_slots_in[i]   = key_slots_ff[i+1];
                     value_slots_in[i] = value_slots_ff[i+1];
                  end
               end
               count_in    = count_ff - 1'b1;
               position_in = POS_BITS'(at);
            end
         end
         OP_SET_VALUE: begin
            if (!found) begin
               status_in = ST_MISSING;
            end else begin
               value_slots_in[at] = q_head.value;
               position_in        = POS_BITS'(at);
            end
         end
         OP_LOOKUP: begin
            if (!found) begin
               status_in = ST_MISSING;
            end else begin
               fval_in     = value_slots_ff[at];
               position_in = POS_BITS'(at);
            end
         end
         OP_RENAME: begin
            if ((q_head.new_key != q_head.key) && nfound) begin
               status_in = ST_DUP;
            end else if (!found) begin
               status_in = ST_MISSING;
            end else begin
               key_slots_in[at] = q_head.new_key;
               position_in      = POS_BITS'(at);
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_NOP: begin
            status_in = ST_OK;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= q_pop;
         if (q_pop) begin
            count_ff <= count_in;
         end
      end
      if (q_pop) begin
         key_slots_ff   <= key_slots_in;
         value_slots_ff <= value_slots_in;
         status_ff      <= status_in;
         position_ff    <= position_in;
         fval_ff        <= fval_in;
         ecount_ff      <= POS_BITS'(count_in);
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_position    = position_ff;
   assign rsp_found_value = fval_ff;
   assign rsp_entry_count = ecount_ff;

endmodule

// ===== rtl/ordered_small_key_value_table.sv =====
// Top level of the ordered key/value table: front end, command queue and
// back end. Depends on okvt_pkg, okvt_front, okvt_queue and okvt_back.
//
//   channel   handshake          transfer                payload
//   request   start & !busy      one command             req_command, req_key,
//                                                        req_value, req_new_key
//   response  rsp_strobe (1 cy)  one result per command  rsp_status, rsp_position,
//                                                        rsp_found_value,
//                                                        rsp_entry_count
//
// A command that is taken is staged in the front-end register, written into the
// queue, then carried out into the result register, which drives the strobe and
// the result. The back end retires one command per cycle; its combinational
// compare-and-shift over all slots sets that rate, so a command can be taken
// every cycle while busy is low.
// Reset (synchronous, active high) empties the table and the queue; slot
// contents are not cleared and are never read until written.
// The receiver cannot stall; busy rises only if the queue fills.
module ordered_small_key_value_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [okvt_pkg::CMD_BITS-1:0]   req_command,
   input  logic [okvt_pkg::KEY_BITS-1:0]   req_key,
   input  logic [okvt_pkg::VALUE_BITS-1:0] req_value,
   input  logic [okvt_pkg::KEY_BITS-1:0]   req_new_key,
   output logic                            rsp_strobe,
   output logic [okvt_pkg::STAT_BITS-1:0]  rsp_status,
   output logic [okvt_pkg::POS_BITS-1:0]   rsp_position,
   output logic [okvt_pkg::VALUE_BITS-1:0] rsp_found_value,
   output logic [okvt_pkg::POS_BITS-1:0]   rsp_entry_count
);
   import okvt_pkg::*;

   // Queue interface: push from the front end, pop by the back end.
   logic      q_push, q_pop;
   entry_type q_in, q_head;
   qstat_type q_stat;

   // Classify and stage incoming commands.
   okvt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_key     (req_key),
      .req_value   (req_value),
      .req_new_key (req_new_key),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_data      (q_in)
   );

   // Decouple the two sides.
   okvt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   // Execute against the table and drive the response strobe.
   okvt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_found_value (rsp_found_value),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// ===== tb/okvt_tb_pkg.sv =====
// Scoreboard for the ordered key/value table bench: a shadow copy of the table
// that predicts every result, plus the queue of results still owed by the block.
// Depends on okvt_pkg.
`timescale 1ns / 100ps
package okvt_tb_pkg;
   import okvt_pkg::*;

   typedef struct packed {
      logic [STAT_BITS-1:0]  status;
      logic [POS_BITS-1:0]   position;
      logic [VALUE_BITS-1:0] found_value;
      logic [POS_BITS-1:0]   entry_count;
   } table_result_type;

   class kv_table_shadow;
      logic [KEY_BITS-1:0]   keys   [CAPACITY];
      logic [VALUE_BITS-1:0] values [CAPACITY];
      int                    fill;
      table_result_type      awaited[$];
      int                    mismatches;
      int                    checked;

      function new();
         fill       = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function int find_key(logic [KEY_BITS-1:0] k);
         for (int i = 0; i < fill; i++)
            if (keys[i] == k) return i;
         return -1;
      endfunction

      // Apply one accepted command to the shadow table and queue its result.
      function void note_command(logic [CMD_BITS-1:0] cmd, logic [KEY_BITS-1:0] k,
                                 logic [VALUE_BITS-1:0] v, logic [KEY_BITS-1:0] nk);
         table_result_type r;
         int               at;
         at       = find_key(k);
         r        = '0;
         r.status = ST_OK;
         case (cmd) inside
            CMD_INS_FRONT, CMD_APPEND: begin
               if (at >= 0) begin
                  r.status = ST_DUP;
               end else if (fill >= CAPACITY) begin
                  r.status = ST_FULL;
               end else if (cmd == CMD_INS_FRONT) begin
                  for (int i = fill; i > 0; i--) begin
                     keys[i]   = keys[i-1];
                     values[i] = values[i-1];
                  end
                  keys[0]   = k;
                  values[0] = v;
                  fill++;
               end else begin
                  keys[fill]   = k;
                  values[fill] = v;
                  r.position   = POS_BITS'(fill);
                  fill++;
               end
            end
            CMD_ERASE: begin
               if (at < 0) begin
                  r.status = ST_MISSING;
               end else begin
                  for (int i = at; i + 1 < fill; i++) begin
                     keys[i]   = keys[i+1];
                     values[i] = values[i+1];
                  end
                  fill--;
                  r.position = POS_BITS'(at);
               end
            end
            CMD_SET_VALUE: begin
               if (at < 0) begin
                  r.status = ST_MISSING;
               end else begin
                  values[at] = v;
                  r.position = POS_BITS'(at);
               end
            end
            CMD_LOOKUP: begin
               if (at < 0) begin
                  r.status = ST_MISSING;
               end else begin
                  r.found_value = values[at];
                  r.position    = POS_BITS'(at);
               end
            end
            CMD_RENAME: begin
               // a clash on the new key wins over a missing old key
               if (nk != k && find_key(nk) >= 0) begin
                  r.status = ST_DUP;
               end else if (at < 0) begin
                  r.status = ST_MISSING;
               end else begin
                  keys[at]   = nk;
                  r.position = POS_BITS'(at);
               end
            end
            CMD_CLEAR: fill = 0;
            default: ;
         endcase
         r.entry_count = POS_BITS'(fill);
         awaited.push_back(r);
      endfunction

      // Compare one result strobe against the oldest outstanding prediction.
      function void check_result(table_result_type got);
         table_result_type want;
         if (awaited.size() == 0) begin
            $error("result with no command outstanding: status %0d position %0d",
                   got.status, got.position);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            mismatches++;
         end
         if (got.found_value !== want.found_value) begin
            $error("found_value: expected %h, actual %h", want.found_value, got.found_value);
            mismatches++;
         end
         if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ===== tb/ordered_small_key_value_table_tb.sv =====
// Top-level bench for ordered_small_key_value_table: drives directed and random
// command traffic and checks each result strobe against the shadow table.
// Depends on okvt_pkg, okvt_tb_pkg and the table RTL.
`timescale 1ns / 100ps
module ordered_small_key_value_table_tb;
   import okvt_pkg::*;
   import okvt_tb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int POOL_SIZE   = 8;
   localparam int SEGMENTS    = 30;
   localparam int SEG_ITEMS   = 60;
   localparam int CALM_SEGS   = 5;   // trailing segments driven back to back

   localparam logic [VALUE_BITS-1:0] VAL_ONES = {VALUE_BITS{1'b1}};
   localparam logic [VALUE_BITS-1:0] VAL_ALT0 = 63'h2AAA_AAAA_AAAA_AAAA;
   localparam logic [VALUE_BITS-1:0] VAL_ALT1 = 63'h5555_5555_5555_5555;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  start       = 1'b0;
   logic [CMD_BITS-1:0]   req_command = '0;
   logic [KEY_BITS-1:0]   req_key     = '0;
   logic [VALUE_BITS-1:0] req_value   = '0;
   logic [KEY_BITS-1:0]   req_new_key = '0;
   logic                  busy;
   logic                  rsp_strobe;
   logic [STAT_BITS-1:0]  rsp_status;
   logic [POS_BITS-1:0]   rsp_position;
   logic [VALUE_BITS-1:0] rsp_found_value;
   logic [POS_BITS-1:0]   rsp_entry_count;

   kv_table_shadow        shadow;
   logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];
   int                    cycle_count = 0;

   ordered_small_key_value_table dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_value       (req_value),
      .req_new_key     (req_new_key),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_found_value (rsp_found_value),
      .rsp_entry_count (rsp_entry_count)
   );

   always #6 clock = ~clock;

   // Watch both channels at the edge. Everything is driven by nonblocking
   // assignments, so the values seen here are the ones the block sampled.
   // Check responses first: a result always belongs to an older transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1)
            shadow.check_result(table_result_type'({rsp_status, rsp_position,
                                                    rsp_found_value, rsp_entry_count}));
         if (start && !busy)
            shadow.note_command(req_command, req_key, req_value, req_new_key);
      end
   end

   // Watchdog: give up well beyond the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, shadow.awaited.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Present one command and hold it until the transfer completes. Start is
   // left high so that a following command goes out on the very next cycle.
   task automatic send_command(input logic [CMD_BITS-1:0] cmd, input logic [KEY_BITS-1:0] k,
                               input logic [VALUE_BITS-1:0] v,
                               input logic [KEY_BITS-1:0] nk);
      start       <= 1'b1;
      req_command <= cmd;
      req_key     <= k;
      req_value   <= v;
      req_new_key <= nk;
      do @(posedge clock); while (busy);
   endtask

   // Drop start for a burst of idle cycles.
   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Hold off the sender until every outstanding result has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (shadow.awaited.size() != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_BITS-1:0] rand_value();
      logic [63:0] raw;
      int          pick;
      pick = $urandom_range(0, 19);
      raw  = {$urandom, $urandom};
      if (pick == 0) return '0;
      if (pick == 1) return VAL_ONES;
      return raw[VALUE_BITS-1:0];
   endfunction

   // Mostly keys from the small pool so that hits, duplicates and a full table
   // are common; now and then any key at all.
   function automatic logic [KEY_BITS-1:0] rand_key();
      if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE-1)];
      return KEY_BITS'($urandom_range(0, 65535));
   endfunction

   function automatic logic [CMD_BITS-1:0] rand_command();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) return CMD_INS_FRONT;
      if (pick < 40) return CMD_APPEND;
      if (pick < 55) return CMD_ERASE;
      if (pick < 67) return CMD_SET_VALUE;
      if (pick < 82) return CMD_LOOKUP;
      if (pick < 94) return CMD_RENAME;
      if (pick < 97) return CMD_CLEAR;
      return CMD_UNUSED;
   endfunction

   // Fresh key pool per segment; the extreme keys show up now and then.
   task automatic refresh_pool();
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = KEY_BITS'($urandom_range(0, 65535));
      if ($urandom_range(0, 2) == 0) key_pool[0] = '0;
      if ($urandom_range(0, 2) == 0) key_pool[1] = '1;
   endtask

   task automatic random_segment(input int items, input int idle_pct);
      logic [KEY_BITS-1:0] k;
      logic [KEY_BITS-1:0] nk;
      int                  pick;
      for (int i = 0; i < items; i++) begin
         k    = rand_key();
         pick = $urandom_range(0, 9);
         if (pick == 0)
            nk = k;                                  // rename onto itself
         else if (pick < 8)
            nk = key_pool[$urandom_range(0, POOL_SIZE-1)];
         else
            nk = KEY_BITS'($urandom_range(0, 65535));
         send_command(rand_command(), k, rand_value(), nk);
         if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            idle_cycles($urandom_range(1, 9));
      end
   endtask

   // Corners: empty-table misses, the unused code, extreme keys and values,
   // duplicate-before-full on insert, clash-before-missing on rename, rename
   // onto itself, erase at front, back and middle, and clear.
   task automatic directed_corners();
      send_command(CMD_LOOKUP,    16'h0000, '0, '0);
      send_command(CMD_ERASE,     16'hFFFF, '0, '0);
      send_command(CMD_SET_VALUE, 16'h0001, VAL_ONES, '0);
      send_command(CMD_RENAME,    16'h0005, '0, 16'h0005);
      send_command(CMD_UNUSED,    16'hFFFF, VAL_ONES, 16'hFFFF);
      send_command(CMD_INS_FRONT, 16'h0000, '0, '0);
      send_command(CMD_APPEND,    16'hFFFF, VAL_ONES, '0);
      send_command(CMD_INS_FRONT, 16'h0000, VAL_ALT1, '0);
      send_command(CMD_APPEND,    16'hFFFF, VAL_ALT0, '0);
      send_command(CMD_INS_FRONT, 16'hAAAA, VAL_ALT1, '0);
      send_command(CMD_APPEND,    16'h5555, VAL_ALT0, '0);
      send_command(CMD_INS_FRONT, 16'h0100, 63'h0123_4567_89AB_CDEF, '0);
      send_command(CMD_APPEND,    16'h8000, 63'h7EDC_BA98_7654_3210, '0);
      // table now full: 0100 AAAA 0000 FFFF 5555 8000
      send_command(CMD_APPEND,    16'h1234, VAL_ONES, '0);
      send_command(CMD_INS_FRONT, 16'h5555, VAL_ONES, '0);
      send_command(CMD_UNUSED,    16'h0000, '0, '0);
      send_command(CMD_LOOKUP,    16'hFFFF, '0, '0);
      send_command(CMD_SET_VALUE, 16'h0000, VAL_ONES, '0);
      send_command(CMD_LOOKUP,    16'h0000, '0, '0);
      send_command(CMD_RENAME,    16'hAAAA, VAL_ONES, 16'h8000);
      send_command(CMD_RENAME,    16'h1234, '0, 16'h5555);
      send_command(CMD_RENAME,    16'h5555, '0, 16'h5555);
      send_command(CMD_RENAME,    16'h8000, '0, 16'h7FFF);
      send_command(CMD_ERASE,     16'h0100, '0, '0);
      send_command(CMD_ERASE,     16'h7FFF, '0, '0);
      send_command(CMD_ERASE,     16'h0000, '0, '0);
      send_command(CMD_CLEAR,     16'hFFFF, VAL_ONES, 16'hFFFF);
   endtask

   initial begin
      shadow = new();
      refresh_pool();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_corners();
      drain_results();

      // Random traffic: each segment picks its own idle density, including
      // none at all; the closing segments run with no idling.
      for (int s = 0; s < SEGMENTS; s++) begin
         int idle_pct;
         refresh_pool();
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 50;
         endcase
         if (s >= SEGMENTS - CALM_SEGS) idle_pct = 0;
         random_segment(SEG_ITEMS, idle_pct);
         if (s == SEGMENTS / 2) drain_results();
      end

      // Let the pipeline empty, then keep watching for stray strobes.
      drain_results();
      repeat (10) @(posedge clock);

      $display("Covered %0d command results: corner sequences, then random traffic",
               shadow.checked);
      $display("over rotating key pools with bursty and back-to-back requests.");
      if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
